@@ rtl/core/lr16k_pkg.sv @@
// ----------------------------------------------------------------------------
// lr16k_pkg
// Shared constants, controller states and the command and status bundles
// of the linear resampler to 16 kHz.
// ----------------------------------------------------------------------------
package lr16k_pkg;

  localparam int TARGET_RATE_DEF    = 16000;
  localparam int WINDOW_SAMPLES_DEF = 4;

  localparam int SAMPLE_W = 16;
  localparam int PCM_W    = 24;
  localparam int RATE_W   = 16;

  localparam logic [RATE_W-1:0] RATE_MIN   = 16'd4000;
  localparam logic [RATE_W-1:0] RATE_MAX   = 16'd48000;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd16000;

  localparam int CREDIT_W       = 17;
  localparam int CREDIT_MAX_VAL = 131071;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 17'h1FFFF;

  localparam int MAX_OUT = 8;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam int DIV_QW    = PCM_W;
  localparam int DIV_STEPS = 5;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LAG_DIV,
    ST_LAG_TEST,
    ST_READ0,
    ST_READ1,
    ST_MUL_A,
    ST_MUL_B,
    ST_PREP,
    ST_BLEND_DIV,
    ST_STEP,
    ST_EMIT,
    ST_EMIT_WAIT,
    ST_DONE,
    ST_BARE,
    ST_BARE_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_lag;
    logic div_blend;
    logic rd_sel;
    logic s0_latch;
    logic mul_a;
    logic mul_b;
    logic step;
    logic emit;
    logic bare;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic credit_ge_rate;
    logic n_lt_max;
    logic div_busy;
    logic lag_small;
    logic last;
    logic n_zero;
    logic out_fire;
  } dp_stat_t;

endpackage

@@ rtl/core/lr16k_div.sv @@
// ----------------------------------------------------------------------------
// lr16k_div
// Divider by a fixed divisor: multiplies by a precomputed reciprocal in four
// half-width partial products, then forms the remainder.
// ----------------------------------------------------------------------------
module lr16k_div
  import lr16k_pkg::*;
#(
  parameter int DIVISOR = TARGET_RATE_DEF,
  localparam int TW = $clog2(DIVISOR + 1),
  localparam int XW = TW + DIV_QW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [XW-1:0]     x_in,
  output logic              busy,
  output logic [DIV_QW-1:0] quot,
  output logic [TW-1:0]     rem
);

  // The shift SH = XW + TW makes the truncated product exact for every
  // dividend below 2**XW.
  localparam int SH = XW + TW;
  localparam int HW = (XW + 3) / 2;
  localparam int AW = 4 * HW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [2*HW-1:0] RECIP_C = (2*HW)'(RECIP);
  localparam logic [XW-1:0]   DIV_X   = XW'(DIVISOR);

  localparam logic [DIV_CNT_W-1:0] PH_LL  = DIV_CNT_W'(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] PH_HL  = DIV_CNT_W'(4);
  localparam logic [DIV_CNT_W-1:0] PH_LH  = DIV_CNT_W'(3);
  localparam logic [DIV_CNT_W-1:0] PH_HH  = DIV_CNT_W'(2);
  localparam logic [DIV_CNT_W-1:0] PH_FIN = DIV_CNT_W'(1);

  logic [2*HW-1:0]      x_r, x_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_QW-1:0]    quot_r, quot_nxt;
  logic [TW-1:0]        rem_r, rem_nxt;
  logic [HW-1:0]        op_a;
  logic [HW-1:0]        op_b;
  logic [2*HW-1:0]      prod;
  logic [DIV_QW-1:0]    q_w;
  logic [XW-1:0]        qd;

  always_comb begin
    case (cnt_r)
      PH_HL: begin
        op_a = x_r[2*HW-1:HW];
        op_b = RECIP_C[HW-1:0];
      end
      PH_LH: begin
        op_a = x_r[HW-1:0];
        op_b = RECIP_C[2*HW-1:HW];
      end
      PH_HH: begin
        op_a = x_r[2*HW-1:HW];
        op_b = RECIP_C[2*HW-1:HW];
      end
      default: begin
        op_a = x_r[HW-1:0];
        op_b = RECIP_C[HW-1:0];
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign q_w  = acc_r[SH +: DIV_QW];
  assign qd   = XW'(q_w) * DIV_X;

  always_comb begin
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      x_nxt   = (2*HW)'(x_in);
      acc_nxt = '0;
      cnt_nxt = PH_LL;
    end else begin
      case (cnt_r)
        PH_LL: begin
          acc_nxt = acc_r + AW'(prod);
        end
        PH_HL, PH_LH: begin
          acc_nxt = acc_r + (AW'(prod) << HW);
        end
        PH_HH: begin
          acc_nxt = acc_r + (AW'(prod) << (2 * HW));
        end
        PH_FIN: begin
          quot_nxt = q_w;
          rem_nxt  = TW'(x_r[XW-1:0] - qd);
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/lr16k_ctrl.sv @@
// ----------------------------------------------------------------------------
// lr16k_ctrl
// Sequencer that walks each input item through its output positions.
// ----------------------------------------------------------------------------
module lr16k_ctrl
  import lr16k_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.n_lt_max && stat.credit_ge_rate) state_nxt = ST_LAG_DIV;
        else state_nxt = ST_DONE;
      end
      ST_LAG_DIV: begin
        if (!stat.div_busy) state_nxt = ST_LAG_TEST;
      end
      ST_LAG_TEST: begin
        if (stat.lag_small && !stat.last) state_nxt = ST_DONE;
        else state_nxt = ST_READ0;
      end
      ST_READ0:  state_nxt = ST_READ1;
      ST_READ1:  state_nxt = ST_MUL_A;
      ST_MUL_A:  state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_BLEND_DIV;
      ST_BLEND_DIV: begin
        if (!stat.div_busy) state_nxt = ST_STEP;
      end
      ST_STEP:   state_nxt = ST_EMIT;
      ST_EMIT:   state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (stat.out_fire) state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (stat.last && stat.n_zero) state_nxt = ST_BARE;
        else state_nxt = ST_IDLE;
      end
      ST_BARE:   state_nxt = ST_BARE_WAIT;
      ST_BARE_WAIT: begin
        if (stat.out_fire) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CHECK: begin
        cmd.div_lag = stat.n_lt_max && stat.credit_ge_rate;
      end
      ST_READ0: begin
        cmd.rd_sel = 1'b0;
      end
      ST_READ1: begin
        cmd.rd_sel   = 1'b1;
        cmd.s0_latch = 1'b1;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
      end
      ST_PREP: begin
        cmd.div_blend = 1'b1;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      ST_DONE: begin
        cmd.clear = stat.last && !stat.n_zero;
      end
      ST_BARE: begin
        cmd.bare = 1'b1;
      end
      ST_BARE_WAIT: begin
        cmd.clear = stat.out_fire;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/lr16k_dp.sv @@
// ----------------------------------------------------------------------------
// lr16k_dp
// Datapath: rate register, sample window, phase credit, blend arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module lr16k_dp
  import lr16k_pkg::*;
#(
  parameter int TARGET_RATE    = TARGET_RATE_DEF,
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last,
  input  logic                cfg_valid,
  input  logic [RATE_W-1:0]   cfg_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [PCM_W-1:0]    out_pcm,
  output logic                out_has_sample,
  output logic                out_eou
);

  localparam int TW    = $clog2(TARGET_RATE + 1);
  localparam int XW    = TW + DIV_QW;
  localparam int IW    = $clog2(WINDOW_SAMPLES);
  localparam int KMAX  = (CREDIT_MAX_VAL + TARGET_RATE - 1) / TARGET_RATE;
  localparam int KW    = $clog2(KMAX + 1);
  localparam int EW    = ((KW > IW) ? KW : IW) + 1;
  localparam int DW    = SAMPLE_W + 1;
  localparam int PW    = DW + TW + 1;
  localparam int S0TW  = SAMPLE_W + TW + 1;
  localparam int VW    = PW + 1;

  localparam logic [TW-1:0] T_C    = TW'(TARGET_RATE);
  localparam logic [TW-1:0] T_M1   = TW'(TARGET_RATE - 1);
  localparam logic [TW-1:0] T_HALF = TW'(TARGET_RATE / 2);

  logic [RATE_W-1:0]   rate_cfg_r;
  logic [RATE_W-1:0]   rate;
  logic [CREDIT_W-1:0] credit_r;
  logic [CREDIT_W:0]   credit_sum;
  logic [CNT_W-1:0]    n_r;
  logic                last_r;

  logic signed [SAMPLE_W-1:0] win_mem [WINDOW_SAMPLES];
  logic [WINDOW_SAMPLES-1:0]  win_val_r;
  logic [IW-1:0]              wr_ptr_r;
  logic [IW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_val_r;
  logic signed [SAMPLE_W-1:0] s1;
  logic signed [SAMPLE_W-1:0] s0_r;

  logic [KW-1:0]         k;
  logic [TW-1:0]         frac;
  logic [KW-1:0]         idx_sel;
  logic [EW-1:0]         idx_e;
  logic [IW-1:0]         idx_c;
  logic [IW:0]           addr_sum;

  logic signed [DW-1:0]   d;
  logic signed [PW-1:0]   prod_r;
  logic signed [S0TW-1:0] s0t_r;
  logic signed [VW-1:0]   v;
  logic [VW-1:0]          mag;
  logic                   neg_r;

  logic              div_start;
  logic [XW-1:0]     div_x;
  logic [XW-1:0]     x_lag;
  logic [XW-1:0]     x_blend;
  logic              div_busy;
  logic [DIV_QW-1:0] div_quot;
  logic [TW-1:0]     div_rem;
  logic [PCM_W-1:0]  pcm;

  logic             out_valid_r;
  logic [PCM_W-1:0] out_pcm_r;
  logic             out_has_r;
  logic             out_eou_r;
  logic             out_fire;

  always_comb begin
    if (rate_cfg_r < RATE_MIN) rate = RATE_MIN;
    else if (rate_cfg_r > RATE_MAX) rate = RATE_MAX;
    else rate = rate_cfg_r;
  end

  assign credit_sum = {1'b0, credit_r} + (CREDIT_W + 1)'(TARGET_RATE);

  assign k    = div_quot[KW-1:0];
  assign frac = T_M1 - div_rem;

  always_comb begin
    if (cmd.rd_sel) begin
      idx_sel = (k >= KW'(2)) ? (k - KW'(2)) : '0;
    end else begin
      idx_sel = k - KW'(1);
    end
    idx_e = EW'(idx_sel);
    if (idx_e > EW'(WINDOW_SAMPLES - 1)) idx_c = IW'(WINDOW_SAMPLES - 1);
    else idx_c = idx_e[IW-1:0];
    addr_sum = (IW + 1)'(wr_ptr_r) + (IW + 1)'(WINDOW_SAMPLES - 1) - (IW + 1)'(idx_c);
    if (addr_sum >= (IW + 1)'(WINDOW_SAMPLES)) begin
      rd_addr = IW'(addr_sum - (IW + 1)'(WINDOW_SAMPLES));
    end else begin
      rd_addr = addr_sum[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) win_mem[wr_ptr_r] <= in_sample;
    rd_data_r <= win_mem[rd_addr];
    rd_val_r  <= win_val_r[rd_addr];
  end

  assign s1 = rd_val_r ? rd_data_r : '0;
  assign d  = DW'(s1) - DW'(s0_r);

  assign v   = VW'(s0t_r) + VW'(prod_r);
  assign mag = v[VW-1] ? VW'(-v) : VW'(v);

  assign x_lag   = XW'(credit_r) + XW'(T_M1);
  assign x_blend = XW'({mag, 8'h00}) + XW'(T_HALF);

  assign div_start = cmd.div_lag | cmd.div_blend;
  assign div_x     = cmd.div_blend ? x_blend : x_lag;

  lr16k_div #(
    .DIVISOR (TARGET_RATE)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x_in  (div_x),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign pcm = neg_r ? (PCM_W'(0) - div_quot) : div_quot;

  always_ff @(posedge clk) begin
    if (cmd.s0_latch) s0_r <= s1;
    if (cmd.mul_a) prod_r <= d * $signed({1'b0, frac});
    if (cmd.mul_b) s0t_r <= s0_r * $signed({1'b0, T_C});
    if (cmd.div_blend) neg_r <= v[VW-1];
    if (cmd.emit) begin
      out_pcm_r <= pcm;
      out_has_r <= 1'b1;
      out_eou_r <= last_r && !(stat.n_lt_max && stat.credit_ge_rate);
    end else if (cmd.bare) begin
      out_pcm_r <= '0;
      out_has_r <= 1'b0;
      out_eou_r <= 1'b1;
    end
  end

  assign out_fire = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_cfg_r  <= RATE_RESET;
      credit_r    <= '0;
      n_r         <= '0;
      last_r      <= 1'b0;
      win_val_r   <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) rate_cfg_r <= cfg_data;
      if (cmd.clear) begin
        credit_r  <= '0;
        win_val_r <= '0;
        wr_ptr_r  <= '0;
        last_r    <= 1'b0;
      end else if (cmd.load) begin
        win_val_r[wr_ptr_r] <= 1'b1;
        if (wr_ptr_r == IW'(WINDOW_SAMPLES - 1)) wr_ptr_r <= '0;
        else wr_ptr_r <= wr_ptr_r + 1'b1;
        if (credit_sum > (CREDIT_W + 1)'(CREDIT_MAX_VAL)) credit_r <= CREDIT_MAX;
        else credit_r <= credit_sum[CREDIT_W-1:0];
        last_r <= in_last;
        n_r    <= '0;
      end else if (cmd.step) begin
        credit_r <= credit_r - CREDIT_W'(rate);
        n_r      <= n_r + 1'b1;
      end
      if (cmd.emit || cmd.bare) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.credit_ge_rate = (credit_r >= CREDIT_W'(rate));
    stat.n_lt_max       = (n_r < CNT_W'(MAX_OUT));
    stat.div_busy       = div_busy;
    stat.lag_small      = (k < KW'(2));
    stat.last           = last_r;
    stat.n_zero         = (n_r == '0);
    stat.out_fire       = out_fire;
  end

  assign out_tvalid     = out_valid_r;
  assign out_pcm        = out_pcm_r;
  assign out_has_sample = out_has_r;
  assign out_eou        = out_eou_r;

endmodule

@@ rtl/core/linear_resampler_to_16k_core.sv @@
// ----------------------------------------------------------------------------
// linear_resampler_to_16k_core
// Linear interpolation sample rate converter from a configured source rate
// to the target rate, with Q1.23 output.
// ----------------------------------------------------------------------------
// The block takes one input sample per transaction and works on it alone
// until all of its results have been taken, up to eight outputs per
// sample. The shared divider multiplies by a fixed reciprocal and runs
// twice per output, once to locate the output between two source samples
// and once to scale the blended value. Closing the item runs it once more
// when the next output still lacks its right-hand neighbor. The source
// rate is to be written by the user through the configuration channel
// between utterances, which the block itself does not enforce, and is
// clamped to 4 kHz to 48 kHz. A final sample that leaves no output
// produces one end marker with tuser low.
module linear_resampler_to_16k_core
  import lr16k_pkg::*;
#(
  parameter int TARGET_RATE    = TARGET_RATE_DEF,
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [PCM_W-1:0]    out_tdata,  // [23:0] pcm_out
  output logic                out_tuser,  // [0] has_sample
  output logic                out_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RATE_W-1:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lr16k_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lr16k_dp #(
    .TARGET_RATE    (TARGET_RATE),
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample      (in_tdata),
    .in_last        (in_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_pcm        (out_tdata),
    .out_has_sample (out_tuser),
    .out_eou        (out_tlast)
  );

  assign cfg_ready = 1'b1;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for linear_resampler_to_16k_core: feeds utterances of signed
// samples at many source rates, predicts the 16 kHz Q1.23 output stream by
// exact rational interpolation and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lr16k_pkg::*;

  localparam int TGT      = TARGET_RATE_DEF;
  localparam int WIN      = WINDOW_SAMPLES_DEF;
  localparam int WDOG_MAX = 5000;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE   = 60;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                lst;
  } sample_item_t;

  typedef struct packed {
    logic [PCM_W-1:0] pcm;
    logic             has;
    logic             eou;
  } pcm_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;  // [15:0] sample
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [PCM_W-1:0]    out_tdata;        // [23:0] pcm_out
  logic                out_tuser;        // [0] has_sample
  logic                out_tlast;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [RATE_W-1:0]   cfg_data   = '0;

  sample_item_t pending_samples[$];
  pcm_result_t  expected_pcm[$];

  logic signed [SAMPLE_W-1:0] hist_win[WIN];
  int unsigned                phase_credit = 0;
  logic [RATE_W-1:0]          model_rate   = RATE_RESET;

  sample_item_t next_item;
  pcm_result_t  want;
  int           err_cnt   = 0;
  int           in_gap    = 0;
  int           out_gap   = 0;
  int           hold_cnt  = 0;
  int           hold_seq  = 0;
  int           hold_seen = 0;
  int           idle_cnt  = 0;
  bit           idle_en   = 1'b1;

  linear_resampler_to_16k_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < WIN; i++) hist_win[i] = '0;
  end

  function automatic logic [PCM_W-1:0] blend_q23(logic signed [SAMPLE_W-1:0] s0,
                                                 logic signed [SAMPLE_W-1:0] s1,
                                                 int unsigned frac);
    longint num;
    longint mag;
    longint q;
    num = (longint'(s0) * TGT + (longint'(s1) - longint'(s0)) * longint'(frac)) * 256;
    mag = (num < 0) ? -num : num;
    q   = (mag + TGT / 2) / TGT;
    if (num < 0) q = -q;
    return q[PCM_W-1:0];
  endfunction

  // Advances the converter state by one sample and queues the outputs it yields.
  function automatic void resample_predict(logic [SAMPLE_W-1:0] smp, logic lst);
    int unsigned rate;
    int unsigned k;
    int unsigned frac;
    int unsigned idx;
    int          n;
    logic signed [SAMPLE_W-1:0] s0;
    logic signed [SAMPLE_W-1:0] s1;
    pcm_result_t res[MAX_OUT];
    rate = model_rate;
    if (model_rate < RATE_MIN) rate = RATE_MIN;
    if (model_rate > RATE_MAX) rate = RATE_MAX;
    for (int i = WIN - 1; i > 0; i--) hist_win[i] = hist_win[i-1];
    hist_win[0] = smp;
    phase_credit += TGT;
    if (phase_credit > CREDIT_MAX_VAL) phase_credit = CREDIT_MAX_VAL;
    n = 0;
    while (n < MAX_OUT && phase_credit >= rate) begin
      k    = (phase_credit + TGT - 1) / TGT;
      frac = k * TGT - phase_credit;
      if (!lst && k < 2) break;
      idx = (k - 1 >= WIN) ? WIN - 1 : k - 1;
      s0  = hist_win[idx];
      if (k >= 2) begin
        idx = (k - 2 >= WIN) ? WIN - 1 : k - 2;
        s1  = hist_win[idx];
      end else begin
        s1 = hist_win[0];
      end
      res[n] = '{pcm: blend_q23(s0, s1, frac), has: 1'b1, eou: 1'b0};
      n++;
      phase_credit -= rate;
    end
    if (lst) begin
      if (n == 0) begin
        res[0] = '{pcm: '0, has: 1'b0, eou: 1'b1};
        n = 1;
      end else begin
        res[n-1].eou = 1'b1;
      end
      for (int i = 0; i < WIN; i++) hist_win[i] = '0;
      phase_credit = 0;
    end
    for (int i = 0; i < n; i++) expected_pcm = {expected_pcm, res[i]};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) model_rate = cfg_data;
      if (in_tvalid && in_tready) resample_predict(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          next_item = pending_samples[0];
          pending_samples.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.smp;
          in_tlast  <= next_item.lst;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pcm.size() == 0) begin
          $error("unexpected result: pcm_out %0d has_sample %0b end_of_utterance %0b",
                 $signed(out_tdata), out_tuser, out_tlast);
          err_cnt++;
        end else begin
          want = expected_pcm[0];
          expected_pcm.delete(0);
          if (out_tdata !== want.pcm) begin
            $error("pcm_out: expected %0d, actual %0d", $signed(want.pcm),
                   $signed(out_tdata));
            err_cnt++;
          end
          if (out_tuser !== want.has) begin
            $error("has_sample: expected %0b, actual %0b", want.has, out_tuser);
            err_cnt++;
          end
          if (out_tlast !== want.eou) begin
            $error("end_of_utterance: expected %0b, actual %0b", want.eou, out_tlast);
            err_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_cnt  = HOLD_LEN - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    case ($urandom_range(0, 9))
      0: return RATE_MIN;
      1: return RATE_MAX;
      2: return 16'($urandom_range(0, 3999));
      3: return 16'($urandom_range(48001, 65535));
      4: begin
        case ($urandom_range(0, 3))
          0: return 16'd8000;
          1: return 16'd11025;
          2: return 16'd22050;
          default: return 16'd44100;
        endcase
      end
      default: return 16'($urandom_range(4000, 48000));
    endcase
  endfunction

  task automatic add_utterance(input int len, input bit close);
    sample_item_t itm;
    for (int i = 0; i < len; i++) begin
      itm = '{smp: rand_sample(), lst: close && (i == len - 1)};
      pending_samples = {pending_samples, itm};
    end
  endtask

  // The block must have finished its current sample before the rate is rewritten.
  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_tvalid || expected_pcm.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_fixed(input logic [SAMPLE_W-1:0] smp, input logic lst);
    sample_item_t itm;
    itm = '{smp: smp, lst: lst};
    pending_samples = {pending_samples, itm};
  endtask

  initial begin
    int queued;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_fixed(16'h7FFF, 1'b0);
    push_fixed(16'h8000, 1'b0);
    push_fixed(16'h0000, 1'b0);
    push_fixed(16'hFFFF, 1'b0);
    push_fixed(16'h0001, 1'b0);
    push_fixed(16'h5555, 1'b0);
    push_fixed(16'hAAAA, 1'b1);

    write_rate(RATE_MAX);
    push_fixed(16'h1234, 1'b1);
    push_fixed(16'h7FFF, 1'b0);
    push_fixed(16'h8000, 1'b0);
    push_fixed(16'h4000, 1'b1);

    write_rate(RATE_MIN);
    push_fixed(16'h7FFF, 1'b0);
    push_fixed(16'h8000, 1'b0);
    push_fixed(16'h0064, 1'b0);
    push_fixed(16'h8000, 1'b1);

    write_rate(16'd0);
    push_fixed(16'h7FFF, 1'b0);
    push_fixed(16'h8001, 1'b1);

    write_rate(16'hFFFF);
    push_fixed(16'h0100, 1'b0);
    push_fixed(16'hFF00, 1'b0);
    push_fixed(16'h7FFF, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      write_rate(rand_rate());
      if (ph >= 8) idle_en = 1'b0;
      queued = 0;
      while (queued < 40) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        add_utterance(len, 1'b1);
        queued += len;
      end
      if ($urandom_range(0, 1) == 1) add_utterance($urandom_range(1, 6), 1'b0);
      if (ph == 3) hold_seq++;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
